[src/efws_pkg.sv]
`default_nettype none
package efws_pkg;

  // Widths of the time and duration words
  localparam int unsigned TIME_W = 48;
  localparam int unsigned DUR_W  = 32;
  localparam int unsigned CFG_W  = 5;
  localparam int unsigned OUT_ID_W = 4;
  // Worker number inside the chain; covers the largest chain of 256 cells
  localparam int unsigned ID_W   = 8;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Search word handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic              found;
    logic [TIME_W-1:0] ftime;
    logic [ID_W-1:0]   id;
  } sweep_t;

  // Free-time write broadcast to the row
  typedef struct packed {
    logic              en;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] ftime;
  } upd_t;

endpackage
`default_nettype wire

[src/efws_cell.sv]
`default_nettype none
module efws_cell import efws_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [CFG_W-1:0] active_workers_i,
  input  wire sweep_t           sweep_i,
  input  wire upd_t             upd_i,
  output sweep_t                sweep_o
);

  logic [TIME_W-1:0] ft_q, ft_d;
  sweep_t            sw_q, sw_d;
  logic              active;
  logic              take;

  // Worker zero always takes part, so a zero count acts as one
  assign active = (IDX == 0) || (32'(active_workers_i) > 32'(IDX));

  // Claim the word when this worker is strictly earlier (ties stay upstream)
  assign take = sweep_i.vld && active && (!sweep_i.found || (ft_q < sweep_i.ftime));

  always_comb begin
    sw_d = sweep_i;
    if (take) begin
      sw_d.found = 1'b1;
      sw_d.ftime = ft_q;
      sw_d.id    = ID_W'(IDX);
    end
  end

  // Write the new free time when this worker is the one picked
  always_comb begin
    ft_d = ft_q;
    if (upd_i.en && (upd_i.id == ID_W'(IDX))) begin
      ft_d = upd_i.ftime;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ft_q <= '0;
      sw_q <= '0;
    end else begin
      ft_q <= ft_d;
      sw_q <= sw_d;
    end
  end

  assign sweep_o = sw_q;

endmodule
`default_nettype wire

[src/earliest_free_worker_scheduler.sv]
`default_nettype none
// Channel | Direction | Handshake                  | Word
// cfg     | in        | cfg_valid_i / cfg_ready_o  | active_workers_i
// in      | in        | in_valid_i / in_ready_o    | duration_i
// out     | out       | out_valid_o / out_ready_i  | worker_id_o, start_time_o
//
// For each job, a search word walks the row of cells,
// one cell per cycle, then the picked free time is written back and the
// result moves to the output register. Jobs are handled one at a time.
// Reset clears all free times to zero and sets active_workers to one.
// A stalled output holds the finished word; the block waits in drain until
// the output register frees up. Config writes are taken in every cycle.
module earliest_free_worker_scheduler import efws_pkg::*; #(
  parameter int unsigned MAX_WORKERS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CFG_W-1:0]    active_workers_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [DUR_W-1:0]    duration_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [OUT_ID_W-1:0]      worker_id_o,
  output logic [TIME_W-1:0]        start_time_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]          st_q, st_d;
  logic [CFG_W-1:0]    act_q;
  logic [DUR_W-1:0]    dur_q;
  sweep_t              head_q, head_d;
  sweep_t              sw [MAX_WORKERS+1];
  sweep_t              tail;
  upd_t                upd;
  logic [TIME_W:0]     sum;
  logic [ID_W-1:0]     res_id_q;
  logic [TIME_W-1:0]   res_time_q;
  logic                out_vld_q, out_vld_d;
  logic [OUT_ID_W-1:0] out_id_q;
  logic [TIME_W-1:0]   out_time_q;
  logic                in_acc;
  logic                out_load;
  logic [MAX_WORKERS:0] tok;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (st_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;

  // Hold the worker count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= CFG_W'(1);
    end else if (cfg_valid_i) begin
      act_q <= active_workers_i;
    end
  end

  // Launch a fresh search word on accept
  always_comb begin
    head_d     = '0;
    head_d.vld = in_acc;
  end

  assign sw[0] = head_q;

  // Row of worker cells
  for (genvar k = 0; k < MAX_WORKERS; k++) begin : g_cell
    efws_cell #(
      .IDX(k)
    ) u_cell (
      .clk_i            (clk_i),
      .rst_ni           (rst_ni),
      .active_workers_i (act_q),
      .sweep_i          (sw[k]),
      .upd_i            (upd),
      .sweep_o          (sw[k+1])
    );
    assign tok[k+1] = sw[k+1].vld;
  end
  assign tok[0] = head_q.vld;

  assign tail = sw[MAX_WORKERS];

  // Advance the picked worker, saturating at the top of the time range
  assign sum = {1'b0, tail.ftime} + {{(TIME_W+1-DUR_W){1'b0}}, dur_q};

  always_comb begin
    upd.en    = tail.vld;
    upd.id    = tail.id;
    upd.ftime = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  end

  // Move the result to the output register once it is free
  assign out_load = (st_q == ST_DRAIN) && (!out_vld_q || out_ready_i);

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:  if (in_acc)    st_d = ST_SWEEP;
      ST_SWEEP: if (tail.vld)  st_d = ST_DRAIN;
      ST_DRAIN: if (out_load)  st_d = ST_IDLE;
      default:                 st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      head_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      head_q    <= head_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dur_q <= duration_i;
    end
    if (tail.vld) begin
      res_id_q   <= tail.id;
      res_time_q <= tail.ftime;
    end
    if (out_load) begin
      out_id_q   <= res_id_q[OUT_ID_W-1:0];
      out_time_q <= res_time_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign worker_id_o  = out_id_q;
  assign start_time_o = out_time_q;

  // Only one search word is ever in the row
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok))
    else $error("more than one search word in flight");

  // A word leaving the row always carries a picked worker
  a_tail_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.vld |-> tail.found)
    else $error("search finished without a worker");

  // The row only produces a word while a search is running
  a_tail_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.vld |-> (st_q == ST_SWEEP))
    else $error("search word outside sweep");

  // An accepted job starts a sweep in the next cycle
  a_acc_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> ((st_q == ST_SWEEP) && head_q.vld))
    else $error("accepted job did not start a sweep");

endmodule
`default_nettype wire

[dv/tb_top.sv]
`default_nettype none
module tb_top;
  import efws_pkg::*;

  localparam int unsigned ROW_LEN = 16;

  // One grant word as the block should report it
  typedef struct {
    logic [OUT_ID_W-1:0] worker;
    logic [TIME_W-1:0]   start;
  } job_grant_t;

  // Track per-worker free times and the grants still owed by the block
  class worker_schedule;
    logic [TIME_W-1:0] free_at [ROW_LEN];
    logic [CFG_W-1:0]  workers;
    job_grant_t        grants_due [$];
    int unsigned       jobs_taken;
    int unsigned       grants_seen;
    int unsigned       saturated_grants;
    int unsigned       bad_grants;

    function new();
      foreach (free_at[i]) free_at[i] = '0;
      workers = CFG_W'(1);
    endfunction

    function int unsigned pending();
      return grants_due.size();
    endfunction

    function void note_fault(string what);
      bad_grants++;
      if (bad_grants <= 10) $display("%s", what);
    endfunction

    // Pick the earliest free worker (lowest number on a tie) and advance it
    function void take_job(logic [DUR_W-1:0] dur);
      int unsigned n;
      int unsigned best;
      logic [TIME_W:0] sum;
      job_grant_t g;
      n = workers;
      if (n == 0) n = 1;
      if (n > ROW_LEN) n = ROW_LEN;
      best = 0;
      for (int unsigned j = 1; j < n; j++)
        if (free_at[j] < free_at[best]) best = j;
      g.worker = OUT_ID_W'(best);
      g.start  = free_at[best];
      grants_due.push_back(g);
      sum = {1'b0, free_at[best]} + (TIME_W+1)'(dur);
      free_at[best] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
      jobs_taken++;
    endfunction

    // Compare one accepted result word with the oldest owed grant
    function void match_grant(logic [OUT_ID_W-1:0] id, logic [TIME_W-1:0] start);
      job_grant_t g;
      grants_seen++;
      if (grants_due.size() == 0) begin
        note_fault($sformatf("unexpected grant: worker_id %0d start_time %0d", id, start));
        return;
      end
      g = grants_due.pop_front();
      if (start === TIME_MAX) saturated_grants++;
      if (id !== g.worker || start !== g.start)
        note_fault($sformatf("grant %0d mismatch: worker_id exp %0d got %0d, start_time exp %0d got %0d",
                             grants_seen, g.worker, id, g.start, start));
    endfunction

    function void close_out();
      if (grants_due.size() != 0)
        note_fault($sformatf("%0d grants never arrived", grants_due.size()));
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_W-1:0]    active_workers_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [DUR_W-1:0]    duration_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [OUT_ID_W-1:0] worker_id_o;
  logic [TIME_W-1:0]   start_time_o;

  worker_schedule sched = new();
  bit          idle_on;
  int unsigned rx_hold;
  int unsigned cfg_writes;

  earliest_free_worker_scheduler #(
    .MAX_WORKERS(ROW_LEN)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .active_workers_i(active_workers_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .duration_i      (duration_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .worker_id_o     (worker_id_o),
    .start_time_o    (start_time_o)
  );

  always #10 clk_i = ~clk_i;

  // Check accepted result words and stall the output in random bursts
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sched.match_grant(worker_id_o, start_time_o);
    if (rx_hold != 0) begin
      rx_hold--;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rx_hold = $urandom_range(0, 14);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Mostly short jobs so that ties between workers come up often
  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2, 3, 4: return DUR_W'($urandom_range(1, 16));
      5, 6:    return DUR_W'($urandom_range(0, 1000));
      7:       return '1;
      default: return DUR_W'($urandom());
    endcase
  endfunction

  // Drop valid and wait until every owed grant has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sched.pending() != 0) @(posedge clk_i);
  endtask

  // Offer one job word, with an optional gap in front of it
  task automatic push_job(input logic [DUR_W-1:0] dur);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    duration_i <= dur;
    do @(posedge clk_i); while (!in_ready_o);
    sched.take_job(dur);
  endtask

  // Write the worker count once the block has gone idle
  task automatic set_workers(input logic [CFG_W-1:0] w);
    drain();
    cfg_valid_i <= 1'b1;
    active_workers_i <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sched.workers = w;
    cfg_writes++;
  endtask

  initial begin
    logic [CFG_W-1:0] w;
    idle_on = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset count of one worker, duration extremes
    push_job('0);
    push_job('1);
    push_job(DUR_W'(1));
    // Full row: ties among idle workers go to the lowest number
    set_workers(CFG_W'(16));
    push_job('0);
    push_job('0);
    push_job(DUR_W'(5));
    push_job(DUR_W'(7));
    push_job('1);
    push_job(DUR_W'(3));
    // Zero workers acts as one
    set_workers(CFG_W'(0));
    push_job(32'hAAAA_AAAA);
    push_job(32'h5555_5555);
    // Counts above the row length clamp to the full row
    set_workers(CFG_W'(31));
    push_job('0);
    push_job('0);
    push_job(DUR_W'(9));
    set_workers(CFG_W'(17));
    push_job(DUR_W'(2));
    push_job(DUR_W'(2));
    // Shrink the row: inactive workers keep their free times
    set_workers(CFG_W'(2));
    push_job(DUR_W'(4));
    push_job('0);
    push_job('1);

    // Random phases, each under its own worker count
    for (int p = 0; p < 6; p++) begin
      idle_on = (p < 5);
      case (p)
        0:       w = CFG_W'(16);
        1:       w = CFG_W'(1);
        2:       w = CFG_W'(0);
        3:       w = CFG_W'(31);
        default: w = CFG_W'($urandom_range(0, 31));
      endcase
      set_workers(w);
      for (int i = 0; i < 250; i++) begin
        if (p < 5 && i % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
        if (p == 2 && i == 125) drain();
        push_job(pick_duration());
      end
    end

    // Push worker 0 with back-to-back maximum jobs
    idle_on = 1'b0;
    set_workers(CFG_W'(1));
    repeat (20) push_job('1);
    push_job('0);
    push_job(DUR_W'($urandom()));
    push_job('1);

    drain();
    repeat (ROW_LEN + 8) @(posedge clk_i);
    sched.close_out();
    $display("Covered %0d jobs and %0d grants under %0d worker-count writes (0 to 31).",
             sched.jobs_taken, sched.grants_seen, cfg_writes);
    $display("Random stalls on both sides, one full drain mid-run, %0d saturated grants.",
             sched.saturated_grants);
    if (sched.bad_grants == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d faults", sched.bad_grants);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #150_000_000;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
src/efws_pkg.sv
src/efws_cell.sv
src/earliest_free_worker_scheduler.sv
dv/tb_top.sv
